@@ sv/hdse_pkg.sv @@
// ----------------------------------------------------------------------------
// hdse_pkg
// Types, codes and marker tables for the hex dump section extractor.
// ----------------------------------------------------------------------------
package hdse_pkg;

    localparam int START_LEN = 13;
    localparam int END_LEN   = 10;
    localparam int POS_W     = 4;

    localparam logic [7:0] CHAR_SPACE   = 8'h20;
    localparam logic [7:0] CHAR_NEWLINE = 8'h0A;
    localparam logic [7:0] CHAR_START0  = 8'h44;  // 'D'
    localparam logic [7:0] CHAR_ZERO    = 8'h30;
    localparam logic [7:0] CHAR_NINE    = 8'h39;
    localparam logic [7:0] CHAR_UPPER_A = 8'h41;
    localparam logic [7:0] CHAR_UPPER_F = 8'h46;

    typedef enum logic [2:0] {
        ST_DATA     = 3'd0,
        ST_DONE     = 3'd1,
        ST_NO_START = 3'd2,
        ST_BAD      = 3'd3,
        ST_NO_END   = 3'd4
    } status_t;

    typedef enum logic [3:0] {
        MODE_SEARCH = 4'b0001,
        MODE_DATA   = 4'b0010,
        MODE_END    = 4'b0100,
        MODE_HALT   = 4'b1000
    } mode_t;

    typedef enum logic [1:0] {
        PH_SEP  = 2'd0,
        PH_HIGH = 2'd1,
        PH_LOW  = 2'd2
    } phase_t;

    typedef struct packed {
        logic        valid;
        status_t     status;
        logic [7:0]  out_byte;
        logic [15:0] byte_total;
    } result_t;

    // "Data Content:"
    function automatic logic [7:0] start_char(input logic [POS_W-1:0] idx);
        logic [7:0] c;
        unique case (idx)
            4'd0:    c = 8'h44;
            4'd1:    c = 8'h61;
            4'd2:    c = 8'h74;
            4'd3:    c = 8'h61;
            4'd4:    c = 8'h20;
            4'd5:    c = 8'h43;
            4'd6:    c = 8'h6F;
            4'd7:    c = 8'h6E;
            4'd8:    c = 8'h74;
            4'd9:    c = 8'h65;
            4'd10:   c = 8'h6E;
            4'd11:   c = 8'h74;
            4'd12:   c = 8'h3A;
            default: c = 8'h00;
        endcase
        return c;
    endfunction

    // "\n# Subtype"
    function automatic logic [7:0] end_char(input logic [POS_W-1:0] idx);
        logic [7:0] c;
        unique case (idx)
            4'd0:    c = 8'h0A;
            4'd1:    c = 8'h23;
            4'd2:    c = 8'h20;
            4'd3:    c = 8'h53;
            4'd4:    c = 8'h75;
            4'd5:    c = 8'h62;
            4'd6:    c = 8'h74;
            4'd7:    c = 8'h79;
            4'd8:    c = 8'h70;
            4'd9:    c = 8'h65;
            default: c = 8'h00;
        endcase
        return c;
    endfunction

    // bit 4 set marks a character that is not an upper-case hex digit
    function automatic logic [4:0] hex_decode(input logic [7:0] c);
        logic [4:0] v;
        if (c >= CHAR_ZERO && c <= CHAR_NINE) begin
            v = {1'b0, 4'(c - CHAR_ZERO)};
        end else if (c >= CHAR_UPPER_A && c <= CHAR_UPPER_F) begin
            v = {1'b0, 4'(c - CHAR_UPPER_A + 8'd10)};
        end else begin
            v = 5'h10;
        end
        return v;
    endfunction

endpackage

@@ sv/hex_dump_section_extractor.sv @@
// ----------------------------------------------------------------------------
// hex_dump_section_extractor
// Finds the "Data Content:" section in a text stream and decodes its hex
// triples into bytes, reporting done or the kind of format fault.
// ----------------------------------------------------------------------------
// a result reaches m_tdata / m_tuser from the input register through the parser and the output register
// throughput: one byte per cycle while the output register is not stalled
// bytes that make no result still take a parser step, even while the output is stalled
// reset: aresetn low clears both stages and rearms the start marker search
// ----------------------------------------------------------------------------
module hex_dump_section_extractor
    import hdse_pkg::*;
#(
    parameter longint unsigned COUNT_MAX = 65535
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,    // byte_value
    input  logic        s_tuser,    // action
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,    // out_byte[7:0], byte_total[23:8]
    output logic [2:0]  m_tuser     // status
);

    logic       in_valid_reg;
    logic [7:0] in_byte_reg;
    logic       in_action_reg;
    logic       step;
    logic       out_ready;
    result_t    result;

    assign step     = in_valid_reg && (!result.valid || out_ready);
    assign s_tready = !in_valid_reg || step;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            in_byte_reg   <= s_tdata;
            in_action_reg <= s_tuser;
        end
    end

    hdse_core #(
        .COUNT_MAX(COUNT_MAX)
    ) u_core (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .step      (step),
        .action    (in_action_reg),
        .byte_value(in_byte_reg),
        .result    (result)
    );

    hdse_out_reg u_out (
        .aclk    (aclk),
        .aresetn (aresetn),
        .load    (step && result.valid),
        .result  (result),
        .ready   (out_ready),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata),
        .m_tuser (m_tuser)
    );

    a_byte_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser != ST_DATA |-> m_tdata[7:0] == 8'h00)
        else $error("nonzero byte on a status transfer");

    a_no_drop: assert property (@(posedge aclk) disable iff (!aresetn)
        in_valid_reg && result.valid && !out_ready |=> in_valid_reg)
        else $error("pending item dropped while output stalled");

endmodule

@@ sv/hdse_core.sv @@
// ----------------------------------------------------------------------------
// hdse_core
// Parser state and per-byte next-state and result logic.
// ----------------------------------------------------------------------------
module hdse_core
    import hdse_pkg::*;
#(
    parameter longint unsigned COUNT_MAX = 65535
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       step,
    input  logic       action,
    input  logic [7:0] byte_value,
    output result_t    result
);

    localparam int CNT_W = $clog2(COUNT_MAX + 1);

    mode_t              mode_reg,   mode_next;
    logic [POS_W-1:0]   pos_reg,    pos_next;
    phase_t             phase_reg,  phase_next;
    logic [3:0]         nib_reg,    nib_next;
    logic [CNT_W-1:0]   cnt_reg,    cnt_next;
    logic [4:0]         hex;

    assign hex = hex_decode(byte_value);

    always_comb begin
        mode_next       = mode_reg;
        pos_next        = pos_reg;
        phase_next      = phase_reg;
        nib_next        = nib_reg;
        cnt_next        = cnt_reg;
        result.valid    = 1'b0;
        result.status   = ST_DATA;
        result.out_byte = 8'h00;
        if (action) begin
            unique case (mode_reg)
                MODE_SEARCH: begin
                    result.valid  = 1'b1;
                    result.status = ST_NO_START;
                end
                MODE_DATA, MODE_END: begin
                    result.valid  = 1'b1;
                    result.status = ST_NO_END;
                end
                default: begin
                    result.valid = 1'b0;
                end
            endcase
            mode_next  = MODE_SEARCH;
            pos_next   = '0;
            phase_next = PH_SEP;
            nib_next   = '0;
            cnt_next   = '0;
        end else begin
            unique case (mode_reg)
                MODE_SEARCH: begin
                    if (byte_value == start_char(pos_reg)) begin
                        if (pos_reg == POS_W'(START_LEN - 1)) begin
                            mode_next  = MODE_DATA;
                            pos_next   = '0;
                            phase_next = PH_SEP;
                        end else begin
                            pos_next = pos_reg + 1'b1;
                        end
                    end else begin
                        pos_next = (byte_value == CHAR_START0) ? POS_W'(1) : '0;
                    end
                end
                MODE_DATA: begin
                    if (phase_reg == PH_SEP) begin
                        if (byte_value == CHAR_SPACE) begin
                            phase_next = PH_HIGH;
                        end else if (byte_value == CHAR_NEWLINE) begin
                            mode_next = MODE_END;
                            pos_next  = POS_W'(1);
                        end else begin
                            mode_next     = MODE_HALT;
                            result.valid  = 1'b1;
                            result.status = ST_BAD;
                        end
                    end else if (hex[4]) begin
                        mode_next     = MODE_HALT;
                        result.valid  = 1'b1;
                        result.status = ST_BAD;
                    end else if (phase_reg == PH_HIGH) begin
                        nib_next   = hex[3:0];
                        phase_next = PH_LOW;
                    end else begin
                        phase_next = PH_SEP;
                        if (cnt_reg < CNT_W'(COUNT_MAX)) begin
                            cnt_next = cnt_reg + 1'b1;
                        end
                        result.valid    = 1'b1;
                        result.status   = ST_DATA;
                        result.out_byte = {nib_reg, hex[3:0]};
                    end
                end
                MODE_END: begin
                    mode_next    = MODE_HALT;
                    result.valid = 1'b1;
                    if (byte_value == end_char(pos_reg)) begin
                        if (pos_reg == POS_W'(END_LEN - 1)) begin
                            result.status = ST_DONE;
                        end else begin
                            mode_next    = MODE_END;
                            pos_next     = pos_reg + 1'b1;
                            result.valid = 1'b0;
                        end
                    end else begin
                        result.status = ST_BAD;
                    end
                end
                default: begin
                    mode_next = MODE_HALT;
                end
            endcase
        end
        // end of input reports the count reached before the rearm
        result.byte_total = action ? 16'(cnt_reg) : 16'(cnt_next);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg  <= MODE_SEARCH;
            pos_reg   <= '0;
            phase_reg <= PH_SEP;
            nib_reg   <= '0;
            cnt_reg   <= '0;
        end else if (step) begin
            mode_reg  <= mode_next;
            pos_reg   <= pos_next;
            phase_reg <= phase_next;
            nib_reg   <= nib_next;
            cnt_reg   <= cnt_next;
        end
    end

    a_rearm: assert property (@(posedge aclk) disable iff (!aresetn)
        step && action |=> mode_reg == MODE_SEARCH && cnt_reg == '0 && pos_reg == '0)
        else $error("end of input did not rearm the search");

    a_search_count: assert property (@(posedge aclk) disable iff (!aresetn)
        mode_reg == MODE_SEARCH |-> cnt_reg == '0)
        else $error("count nonzero while searching");

    a_count_limit: assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg <= CNT_W'(COUNT_MAX))
        else $error("count beyond limit");

    a_phase_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        mode_reg == MODE_SEARCH |-> phase_reg == PH_SEP)
        else $error("triple phase active while searching");

endmodule

@@ sv/hdse_out_reg.sv @@
// ----------------------------------------------------------------------------
// hdse_out_reg
// Result register toward the master-side stream.
// ----------------------------------------------------------------------------
module hdse_out_reg
    import hdse_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        load,
    input  result_t     result,
    output logic        ready,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,    // out_byte[7:0], byte_total[23:8]
    output logic [2:0]  m_tuser     // status
);

    logic        valid_reg;
    logic [23:0] data_reg;
    logic [2:0]  user_reg;

    assign ready    = !valid_reg || m_tready;
    assign m_tvalid = valid_reg;
    assign m_tdata  = data_reg;
    assign m_tuser  = user_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (ready) begin
            valid_reg <= load;
        end
    end

    always_ff @(posedge aclk) begin
        if (ready && load) begin
            data_reg <= {result.byte_total, result.out_byte};
            user_reg <= result.status;
        end
    end

endmodule
